### hdl/dvu_pkg.sv
// Shared constants, types and arithmetic helpers for the drag velocity update.
package dvu_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 16;
	localparam int NCOMP      = 3;
	localparam int DIV_STEPS  = 32;
	localparam int DEN_W      = 48;
	localparam int IN_W       = 272;
	localparam int OUT_W      = 96;
	localparam int USER_W     = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	// Two front stages, the f divider, three middle stages, the quotient divider, output.
	localparam int PIPE_DEPTH = 2 + DIV_STEPS + 3 + DIV_STEPS + 1;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMPLICIT  = 8'd1;
	localparam logic [30:0] TIME_STEP_RST = 31'd65536;
	localparam logic        IMPLICIT_RST  = 1'b1;
	localparam logic [DEN_W-1:0] ONE_Q = 48'd65536;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [31:0]      low;
		logic [31:0]      q;
	} div_t;

	typedef struct packed {
		logic [NCOMP-1:0][31:0] v;
		logic [NCOMP-1:0][31:0] d;
		logic [NCOMP-1:0][31:0] e;
		logic [30:0]            a;
		logic                   mode;
		logic                   err;
		logic                   fsat;
		logic                   esat;
	} side_a_t;

	typedef struct packed {
		logic [NCOMP-1:0][31:0] r;
		logic [NCOMP-1:0]       neg;
		logic [NCOMP-1:0]       qsat;
		logic                   mode;
		logic                   err;
		logic                   sat;
	} side_b_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] val;
	} clip_t;

	// One restoring division step; the partial remainder stays below the divisor.
	function automatic div_t div_step(div_t x);
		logic [DEN_W:0]   r2;
		logic [DEN_W+1:0] diff;
		div_t             y;
		r2    = {x.rem, x.low[31]};
		diff  = {1'b0, r2} - {2'b00, x.den};
		y     = x;
		y.low = {x.low[30:0], 1'b0};
		if (!diff[DEN_W+1]) begin
			y.rem = diff[DEN_W-1:0];
			y.q   = {x.q[30:0], 1'b1};
		end else begin
			y.rem = r2[DEN_W-1:0];
			y.q   = {x.q[30:0], 1'b0};
		end
		return y;
	endfunction

	function automatic logic [31:0] mag32(logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	function automatic clip_t clip_word(logic [49:0] x);
		clip_t c;
		c.hit = 1'b0;
		c.val = x[31:0];
		if (!x[49] && (x[48:31] != '0)) begin
			c.hit = 1'b1;
			c.val = 32'h7FFF_FFFF;
		end else if (x[49] && (x[48:31] != '1)) begin
			c.hit = 1'b1;
			c.val = 32'h8000_0000;
		end
		return c;
	endfunction

endpackage

### hdl/dvu_front.sv
// Front stages: field unpacking, density product, A*v and the explicit error term.
module dvu_front (
	input  logic                      clk,
	input  logic                      en,
	input  logic [dvu_pkg::IN_W-1:0]  tdata,
	input  logic [30:0]               dt,
	input  logic                      mode,
	output dvu_pkg::div_t             fdin,
	output dvu_pkg::side_a_t          sa
);

	logic [dvu_pkg::NCOMP-1:0][31:0] v_in, d_in;
	logic [30:0] a_in, rho_in;
	logic [16:0] ep_in;

	assign v_in[0] = tdata[31:0];
	assign v_in[1] = tdata[63:32];
	assign v_in[2] = tdata[95:64];
	assign d_in[0] = tdata[127:96];
	assign d_in[1] = tdata[159:128];
	assign d_in[2] = tdata[191:160];
	assign a_in    = tdata[222:192];
	assign rho_in  = tdata[253:223];
	assign ep_in   = tdata[270:254];

	logic [dvu_pkg::NCOMP-1:0][31:0] v_s1, d_s1;
	logic [dvu_pkg::NCOMP-1:0][62:0] pm_s1;
	logic [dvu_pkg::NCOMP-1:0]       vneg_s1;
	logic [dvu_pkg::DEN_W-1:0]       prod_s1;
	logic [30:0]                     a_s1, dt_s1;
	logic                            mode_s1, err_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < dvu_pkg::NCOMP; k++) begin
				v_s1[k]    <= v_in[k];
				d_s1[k]    <= d_in[k];
				vneg_s1[k] <= v_in[k][31];
				pm_s1[k]   <= {31'd0, dvu_pkg::mag32(v_in[k])} * {32'd0, a_in};
			end
			prod_s1 <= {17'd0, rho_in} * {31'd0, ep_in};
			err_s1  <= (rho_in == '0) || (ep_in == '0);
			a_s1    <= a_in;
			dt_s1   <= dt;
			mode_s1 <= mode;
		end
	end

	logic [dvu_pkg::NCOMP-1:0][49:0] ediff;
	dvu_pkg::clip_t                  eclip [dvu_pkg::NCOMP];
	logic [dvu_pkg::NCOMP-1:0][49:0] pterm;
	logic                            fsat;

	always_comb begin
		for (int k = 0; k < dvu_pkg::NCOMP; k++) begin
			pterm[k] = vneg_s1[k] ? -{3'd0, pm_s1[k][62:16]} : {3'd0, pm_s1[k][62:16]};
			ediff[k] = {{18{d_s1[k][31]}}, d_s1[k]} - pterm[k];
			eclip[k] = dvu_pkg::clip_word(ediff[k]);
		end
	end

	// The quotient reaches 2^32 exactly when dt is not below the density product.
	assign fsat = {17'd0, dt_s1} >= prod_s1;

	dvu_pkg::div_t    fdin_s2;
	dvu_pkg::side_a_t sa_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			fdin_s2.rem <= fsat ? '0 : {17'd0, dt_s1};
			fdin_s2.den <= prod_s1;
			fdin_s2.low <= '0;
			fdin_s2.q   <= '0;
			for (int k = 0; k < dvu_pkg::NCOMP; k++) begin
				sa_s2.v[k] <= v_s1[k];
				sa_s2.d[k] <= d_s1[k];
				sa_s2.e[k] <= eclip[k].val;
			end
			sa_s2.a    <= a_s1;
			sa_s2.mode <= mode_s1;
			sa_s2.err  <= err_s1;
			sa_s2.fsat <= fsat;
			sa_s2.esat <= eclip[0].hit | eclip[1].hit | eclip[2].hit;
		end
	end

	assign fdin = fdin_s2;
	assign sa   = sa_s2;

endmodule

### hdl/dvu_fdiv.sv
// Pipelined divider for the time factor f, one quotient bit per stage.
module dvu_fdiv (
	input  logic             clk,
	input  logic             en,
	input  dvu_pkg::div_t    din,
	input  dvu_pkg::side_a_t sin,
	output dvu_pkg::div_t    dout,
	output dvu_pkg::side_a_t sout
);

	dvu_pkg::div_t    st_q [dvu_pkg::DIV_STEPS];
	dvu_pkg::side_a_t sd_q [dvu_pkg::DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= dvu_pkg::div_step(din);
			sd_q[0] <= sin;
			for (int i = 1; i < dvu_pkg::DIV_STEPS; i++) begin
				st_q[i] <= dvu_pkg::div_step(st_q[i-1]);
				sd_q[i] <= sd_q[i-1];
			end
		end
	end

	assign dout = st_q[dvu_pkg::DIV_STEPS-1];
	assign sout = sd_q[dvu_pkg::DIV_STEPS-1];

endmodule

### hdl/dvu_mid.sv
// Middle stages: products with f, explicit result and set-up of the implicit division.
module dvu_mid (
	input  logic                              clk,
	input  logic                              en,
	input  dvu_pkg::div_t                     fq,
	input  dvu_pkg::side_a_t                  sa,
	output dvu_pkg::div_t [dvu_pkg::NCOMP-1:0] qdin,
	output dvu_pkg::side_b_t                  sb
);

	logic [31:0] f;
	logic [dvu_pkg::NCOMP-1:0][31:0] x;

	assign f = sa.fsat ? 32'hFFFF_FFFF : fq.q;

	always_comb begin
		for (int k = 0; k < dvu_pkg::NCOMP; k++)
			x[k] = sa.mode ? sa.d[k] : sa.e[k];
	end

	logic [dvu_pkg::NCOMP-1:0][63:0] mm_s35;
	logic [dvu_pkg::NCOMP-1:0]       xneg_s35;
	logic [62:0]                     af_s35;
	logic [dvu_pkg::NCOMP-1:0][31:0] v_s35;
	logic                            mode_s35, err_s35, fsat_s35, esat_s35;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < dvu_pkg::NCOMP; k++) begin
				mm_s35[k]   <= {32'd0, dvu_pkg::mag32(x[k])} * {32'd0, f};
				xneg_s35[k] <= x[k][31];
				v_s35[k]    <= sa.v[k];
			end
			af_s35   <= {32'd0, sa.a} * {31'd0, f};
			mode_s35 <= sa.mode;
			err_s35  <= sa.err;
			fsat_s35 <= sa.fsat;
			esat_s35 <= sa.esat;
		end
	end

	// Sum v plus the scaled term: the explicit result before clipping, or the
	// implicit numerator.
	logic [dvu_pkg::NCOMP-1:0][49:0] t_s36;
	logic [dvu_pkg::DEN_W-1:0]       m_s36;
	logic [dvu_pkg::NCOMP-1:0][31:0] v_s36;
	logic                            mode_s36, err_s36, fsat_s36, esat_s36;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < dvu_pkg::NCOMP; k++) begin
				t_s36[k] <= {{18{v_s35[k][31]}}, v_s35[k]}
					+ (xneg_s35[k] ? -{2'd0, mm_s35[k][63:16]} : {2'd0, mm_s35[k][63:16]});
				v_s36[k] <= v_s35[k];
			end
			m_s36    <= dvu_pkg::ONE_Q + {1'b0, af_s35[62:16]};
			mode_s36 <= mode_s35;
			err_s36  <= err_s35;
			fsat_s36 <= fsat_s35;
			esat_s36 <= esat_s35;
		end
	end

	dvu_pkg::clip_t                  tclip [dvu_pkg::NCOMP];
	logic [dvu_pkg::NCOMP-1:0][49:0] tneg;
	logic [dvu_pkg::NCOMP-1:0][47:0] mn;
	logic [dvu_pkg::NCOMP-1:0]       qsat;
	logic                            xsat;

	always_comb begin
		for (int k = 0; k < dvu_pkg::NCOMP; k++) begin
			tclip[k] = dvu_pkg::clip_word(t_s36[k]);
			tneg[k]  = -t_s36[k];
			mn[k]    = t_s36[k][49] ? tneg[k][47:0] : t_s36[k][47:0];
			qsat[k]  = {16'd0, mn[k][47:16]} >= m_s36;
		end
	end

	assign xsat = tclip[0].hit | tclip[1].hit | tclip[2].hit;

	dvu_pkg::div_t [dvu_pkg::NCOMP-1:0] qd_s37;
	dvu_pkg::side_b_t                   sb_s37;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < dvu_pkg::NCOMP; k++) begin
				qd_s37[k].rem  <= qsat[k] ? '0 : {16'd0, mn[k][47:16]};
				qd_s37[k].den  <= m_s36;
				qd_s37[k].low  <= {mn[k][15:0], 16'd0};
				qd_s37[k].q    <= '0;
				sb_s37.r[k]    <= err_s36 ? v_s36[k] : tclip[k].val;
				sb_s37.neg[k]  <= t_s36[k][49];
				sb_s37.qsat[k] <= qsat[k];
			end
			sb_s37.mode <= mode_s36;
			sb_s37.err  <= err_s36;
			sb_s37.sat  <= fsat_s36 | (!mode_s36 & (esat_s36 | xsat));
		end
	end

	assign qdin = qd_s37;
	assign sb   = sb_s37;

endmodule

### hdl/dvu_qdiv.sv
// Three-lane pipelined divider for the implicit update, one quotient bit per stage.
module dvu_qdiv (
	input  logic                               clk,
	input  logic                               en,
	input  dvu_pkg::div_t [dvu_pkg::NCOMP-1:0] din,
	input  dvu_pkg::side_b_t                   sin,
	output dvu_pkg::div_t [dvu_pkg::NCOMP-1:0] dout,
	output dvu_pkg::side_b_t                   sout
);

	dvu_pkg::div_t [dvu_pkg::NCOMP-1:0] st_q [dvu_pkg::DIV_STEPS];
	dvu_pkg::side_b_t                   sd_q [dvu_pkg::DIV_STEPS];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < dvu_pkg::NCOMP; k++)
				st_q[0][k] <= dvu_pkg::div_step(din[k]);
			sd_q[0] <= sin;
			for (int i = 1; i < dvu_pkg::DIV_STEPS; i++) begin
				for (int k = 0; k < dvu_pkg::NCOMP; k++)
					st_q[i][k] <= dvu_pkg::div_step(st_q[i-1][k]);
				sd_q[i] <= sd_q[i-1];
			end
		end
	end

	assign dout = st_q[dvu_pkg::DIV_STEPS-1];
	assign sout = sd_q[dvu_pkg::DIV_STEPS-1];

endmodule

### hdl/drag_velocity_update.sv
// Top level of the drag velocity update pipeline.
//
//  channel   ports                               direction  content
//  s_*       s_tvalid s_tready s_tdata           in         one fluid cell
//  m_*       m_tvalid m_tready m_tdata m_tuser   out        updated velocity and flags
//  cfg_*     cfg_valid cfg_ready cfg_index/data  in         register writes
//
// One cell is taken per cycle while the output is not stalled; a result passes the front
// stages, the two 32-stage divider pipelines (f, then the implicit quotient) and the output.
// Reset clears the valid bits and loads the registers with their defaults.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated;
// the input is ready whenever the output register is empty or being taken.
module drag_velocity_update (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// vel_x, vel_y, vel_z, drag_src_x, drag_src_y, drag_src_z, drag_coef,
	// density, volume_fraction, one zero pad bit
	input  logic [dvu_pkg::IN_W-1:0]         s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// new_vel_x, new_vel_y, new_vel_z
	output logic [dvu_pkg::OUT_W-1:0]        m_tdata,
	// divide_error, saturated
	output logic [dvu_pkg::USER_W-1:0]       m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dvu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dvu_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic [30:0] dt_q;
	logic        mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q   <= dvu_pkg::TIME_STEP_RST;
			mode_q <= dvu_pkg::IMPLICIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dvu_pkg::REG_TIME_STEP: dt_q   <= cfg_data[30:0];
				dvu_pkg::REG_IMPLICIT:  mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic                            en;
	logic [dvu_pkg::PIPE_DEPTH-1:0]  vld_q;

	assign en       = !vld_q[dvu_pkg::PIPE_DEPTH-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[dvu_pkg::PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[dvu_pkg::PIPE_DEPTH-2:0], s_tvalid};
	end

	dvu_pkg::div_t                      fdin, fdout;
	dvu_pkg::side_a_t                   sa_in, sa_out;
	dvu_pkg::div_t [dvu_pkg::NCOMP-1:0] qdin, qdout;
	dvu_pkg::side_b_t                   sb_in, sb_out;

	dvu_front u_front (
		.clk   (clk),
		.en    (en),
		.tdata (s_tdata),
		.dt    (dt_q),
		.mode  (mode_q),
		.fdin  (fdin),
		.sa    (sa_in)
	);

	dvu_fdiv u_fdiv (
		.clk  (clk),
		.en   (en),
		.din  (fdin),
		.sin  (sa_in),
		.dout (fdout),
		.sout (sa_out)
	);

	dvu_mid u_mid (
		.clk  (clk),
		.en   (en),
		.fq   (fdout),
		.sa   (sa_out),
		.qdin (qdin),
		.sb   (sb_in)
	);

	dvu_qdiv u_qdiv (
		.clk  (clk),
		.en   (en),
		.din  (qdin),
		.sin  (sb_in),
		.dout (qdout),
		.sout (sb_out)
	);

	logic [dvu_pkg::NCOMP-1:0][31:0] qv, res;
	logic [dvu_pkg::NCOMP-1:0]       qhit;

	// Signed quotient clip: a negative result may reach -2^31, a positive one 2^31 - 1.
	always_comb begin
		for (int k = 0; k < dvu_pkg::NCOMP; k++) begin
			if (sb_out.neg[k]) begin
				qhit[k] = sb_out.qsat[k] || (qdout[k].q > 32'h8000_0000);
				qv[k]   = qhit[k] ? 32'h8000_0000 : (~qdout[k].q + 32'd1);
			end else begin
				qhit[k] = sb_out.qsat[k] || qdout[k].q[31];
				qv[k]   = qhit[k] ? 32'h7FFF_FFFF : qdout[k].q;
			end
			res[k] = (sb_out.err || !sb_out.mode) ? sb_out.r[k] : qv[k];
		end
	end

	logic [dvu_pkg::OUT_W-1:0]  data_q;
	logic [dvu_pkg::USER_W-1:0] user_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q    <= res;
			user_q[0] <= sb_out.err;
			user_q[1] <= !sb_out.err && (sb_out.sat || (sb_out.mode && (qhit != '0)));
		end
	end

	assign m_tdata = data_q;
	assign m_tuser = user_q;

endmodule
